### design/nlp_pkg.sv
// shared types and constants of the numeric literal parser
package nlp_pkg;

  localparam int OUT_VALUE_W = 64;

  localparam logic [1:0] PH_START  = 2'd0;
  localparam logic [1:0] PH_ZERO   = 2'd1;
  localparam logic [1:0] PH_DIGITS = 2'd2;

  localparam logic [1:0] RX_DEC = 2'd0;
  localparam logic [1:0] RX_HEX = 2'd1;
  localparam logic [1:0] RX_BIN = 2'd2;
  localparam logic [1:0] RX_OCT = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_INVALID  = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_F = 8'h66;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_F = 8'h46;
  localparam logic [7:0] CH_LOWER_X = 8'h78;
  localparam logic [7:0] CH_LOWER_B = 8'h62;

  localparam logic [4:0] NO_DIGIT = 5'd16;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } in_word_t;

  typedef struct packed {
    logic [OUT_VALUE_W-1:0] value;
    logic [1:0]             status;
  } out_word_t;

  typedef struct packed {
    logic [1:0] phase;
    logic [1:0] radix;
    logic       digit_seen;
    logic       stray_seen;
    logic       overflow_seen;
  } nlp_flags_t;

endpackage

### design/nlp_step.sv
// one character step: prefix decode, digit check, shift-add and result
module nlp_step import nlp_pkg::*; #(
  parameter int VALUE_BITS = 64
) (
  input  in_word_t              word,
  input  nlp_flags_t            flags,
  input  logic [VALUE_BITS-1:0] acc,
  output nlp_flags_t            flags_next,
  output logic [VALUE_BITS-1:0] acc_next,
  output logic                  res_valid,
  output out_word_t             res
);

  localparam int WIDE_W = VALUE_BITS + 5;

  logic [7:0]        c;
  logic [4:0]        digit;
  logic [4:0]        base;
  logic [1:0]        rx_eff;
  logic              do_take;
  logic [WIDE_W-1:0] acc_w;
  logic [WIDE_W-1:0] prod;
  logic [WIDE_W-1:0] wide;
  nlp_flags_t        f;
  nlp_flags_t        ft;
  logic [VALUE_BITS-1:0] a;
  logic              zero_only;
  logic [1:0]        status;

  assign c     = word.char_code;
  assign acc_w = WIDE_W'(acc);

  always_comb begin
    if (c >= CH_ZERO && c <= CH_NINE) begin
      digit = 5'(c - CH_ZERO);
    end else if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
      digit = 5'(c - CH_LOWER_A) + 5'd10;
    end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
      digit = 5'(c - CH_UPPER_A) + 5'd10;
    end else begin
      digit = NO_DIGIT;
    end
  end

  always_comb begin
    f         = flags;
    rx_eff    = flags.radix;
    do_take   = 1'b0;
    zero_only = 1'b0;
    unique case (flags.phase)
      PH_START: begin
        if (c == CH_ZERO) begin
          f.phase   = PH_ZERO;
          zero_only = word.last_char;
        end else begin
          f.radix = RX_DEC;
          f.phase = PH_DIGITS;
          rx_eff  = RX_DEC;
          do_take = 1'b1;
        end
      end
      PH_ZERO: begin
        f.phase = PH_DIGITS;
        if (c == CH_LOWER_X) begin
          f.radix = RX_HEX;
        end else if (c == CH_LOWER_B) begin
          f.radix = RX_BIN;
        end else begin
          f.radix = RX_OCT;
          rx_eff  = RX_OCT;
          do_take = 1'b1;
        end
      end
      default: begin
        f.phase = PH_DIGITS;
        do_take = 1'b1;
      end
    endcase
  end

  always_comb begin
    unique case (rx_eff)
      RX_HEX: begin
        base = 5'd16;
        prod = acc_w << 4;
      end
      RX_BIN: begin
        base = 5'd2;
        prod = acc_w << 1;
      end
      RX_OCT: begin
        base = 5'd8;
        prod = acc_w << 3;
      end
      default: begin
        base = 5'd10;
        prod = (acc_w << 3) + (acc_w << 1);
      end
    endcase
    wide = prod + WIDE_W'(digit);
  end

  always_comb begin
    ft = f;
    a  = acc;
    if (do_take && !flags.stray_seen && !flags.overflow_seen) begin
      if (digit >= base) begin
        ft.stray_seen = 1'b1;
      end else begin
        ft.digit_seen = 1'b1;
        if (wide[WIDE_W-1:VALUE_BITS] != '0) begin
          ft.overflow_seen = 1'b1;
        end else begin
          a = wide[VALUE_BITS-1:0];
        end
      end
    end
  end

  always_comb begin
    if (zero_only) begin
      status = ST_OK;
    end else if (ft.overflow_seen) begin
      status = ST_OVERFLOW;
    end else if (!ft.digit_seen || ft.stray_seen) begin
      status = ST_INVALID;
    end else begin
      status = ST_OK;
    end
  end

  assign res_valid  = word.last_char;
  assign res.status = status;
  assign res.value  = (status == ST_OK && !zero_only) ? OUT_VALUE_W'(a) : '0;

  always_comb begin
    if (word.last_char) begin
      flags_next = '{phase: PH_START, radix: RX_DEC, digit_seen: 1'b0,
                     stray_seen: 1'b0, overflow_seen: 1'b0};
      acc_next   = '0;
    end else begin
      flags_next = ft;
      acc_next   = a;
    end
  end

endmodule

### design/numeric_literal_parser.sv
// top level of the numeric literal parser: input register, step unit, result register
//
// char channel: one word per character of a C-style integer literal, with
//   last_char set on the final character of the token. result channel: one
//   word per token (value and status), given for the word that carries
//   last_char; status is ok, invalid or overflow, and value is zero unless ok.
// a word accepted is held in the input register and processed there by the step
//   unit; its result is then loaded into the result register, which raises
//   result_valid.
// throughput is one character per cycle while char_stall is low: the step is
//   a single shift-add by the base plus the digit and width check, closing on the accumulator.
// VALUE_BYTES sets the accumulator width; longer values report overflow.
// reset empties both registers and clears the token state (start of token, decimal).
// while the result register is full and stalled, a further result-bearing
//   word waits in the input register and char_stall rises; words that carry
//   no result keep flowing.
module numeric_literal_parser import nlp_pkg::*; #(
  parameter int VALUE_BYTES = 8
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      char_valid,
  output logic      char_stall,
  input  in_word_t  char_word,
  output logic      result_valid,
  input  logic      result_stall,
  output out_word_t result_word
);

  localparam int VALUE_BITS = VALUE_BYTES * 8;

  logic                  held;
  in_word_t              held_word;
  nlp_flags_t            flags;
  nlp_flags_t            flags_next;
  logic [VALUE_BITS-1:0] acc;
  logic [VALUE_BITS-1:0] acc_next;
  logic                  res_valid;
  out_word_t             res;
  logic                  advance;
  logic                  take_in;
  logic                  out_free;

  nlp_step #(.VALUE_BITS(VALUE_BITS)) u_step (
    .word       (held_word),
    .flags      (flags),
    .acc        (acc),
    .flags_next (flags_next),
    .acc_next   (acc_next),
    .res_valid  (res_valid),
    .res        (res)
  );

  assign out_free   = !result_valid || !result_stall;
  assign advance    = held && (!res_valid || out_free);
  assign char_stall = held && !advance;
  assign take_in    = char_valid && !char_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (take_in) begin
      held <= 1'b1;
    end else if (advance) begin
      held <= 1'b0;
    end
    if (take_in) begin
      held_word <= char_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '{phase: PH_START, radix: RX_DEC, digit_seen: 1'b0,
                 stray_seen: 1'b0, overflow_seen: 1'b0};
      acc   <= '0;
    end else if (advance) begin
      flags <= flags_next;
      acc   <= acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance && res_valid) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
    if (advance && res_valid) begin
      result_word <= res;
    end
  end

  a_empty_out_takes: assert property (@(posedge clk) disable iff (rst)
    (held && !result_valid) |-> !char_stall)
    else $error("input held back with result register empty");

  a_reset_state: assert property (@(posedge clk)
    rst |=> (flags.phase == PH_START && acc == '0 && !held && !result_valid))
    else $error("token state not cleared by reset");

  a_overflow_digit: assert property (@(posedge clk) disable iff (rst)
    flags.overflow_seen |-> flags.digit_seen)
    else $error("overflow flagged without any digit");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (advance && res_valid) |=> result_valid)
    else $error("finished token produced no result");

endmodule
